>>> rtl/core/utf8d_pkg.sv
// Shared types, constants and helpers for the UTF-8 to code point decoder.
// No dependencies; imported by every module of the core.
`default_nettype none

package utf8d_pkg;

    // Width of the consumed and written counters (saturating).
    localparam int CNT_W = 16;
    localparam int CP_W  = 21;
    localparam int FLD_W = 16;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 16;
    localparam int NRES = 3;

    localparam logic [CP_W-1:0] REPL_CHAR = 21'h00FFFD;

    typedef enum logic [2:0] {
        ST_CHAR = 3'd0,
        ST_REPL = 3'd1,
        ST_STOP = 3'd2,
        ST_FULL = 3'd3,
        ST_END  = 3'd4
    } status_t;

    localparam logic [CFG_IDX_W-1:0] REG_FIX_MODE  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_TERM = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_START = 4'd3;

    typedef struct packed {
        logic             fix_mode;
        logic             zero_term;
        logic [FLD_W-1:0] out_limit;
        logic [FLD_W-1:0] out_start;
    } cfg_t;

    typedef struct packed {
        logic [CP_W-1:0]  partial;
        logic [1:0]       expected;
        logic [1:0]       seen;
        logic             halted;
        logic [CNT_W-1:0] consumed;
        logic [CNT_W-1:0] written;
    } dec_state_t;

    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        status_t          status;
        logic [FLD_W-1:0] bytes_used;
        logic [FLD_W-1:0] chars_out;
        logic             last_result;
    } result_t;

    // Low FLD_W bits of a counter, zero-extended when the counter is narrower.
    function automatic logic [FLD_W-1:0] cnt_to_fld(input logic [CNT_W-1:0] c);
        logic [31:0] w;
        w = 32'(c);
        return w[FLD_W-1:0];
    endfunction

    // Counter value loaded from a 16-bit register: its low CNT_W bits.
    function automatic logic [CNT_W-1:0] fld_to_cnt(input logic [FLD_W-1:0] f);
        logic [31:0] w;
        w = 32'(f);
        return w[CNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/utf8d_step.sv
// Per-byte decode: next decoder state and up to three results for one byte.
// Depends on utf8d_pkg.
`default_nettype none

module utf8d_step (
    input  utf8d_pkg::cfg_t       cfg,
    input  utf8d_pkg::dec_state_t st_cur,
    input  logic [7:0]            in_byte,
    input  logic                  last_byte,
    output utf8d_pkg::dec_state_t st_next,
    output utf8d_pkg::result_t    res [utf8d_pkg::NRES],
    output logic [1:0]            res_cnt
);
    import utf8d_pkg::*;

    typedef struct packed {
        dec_state_t st;
        result_t    r;
    } fail_t;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] c,
                                                input logic [2:0] d);
        logic [CNT_W:0] sum;
        sum = {1'b0, c} + (CNT_W+1)'(d);
        if (sum[CNT_W]) begin
            return {CNT_W{1'b1}};
        end
        return sum[CNT_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] inc_written(input logic [CNT_W-1:0] w,
                                                    input logic [FLD_W-1:0] lim);
        if ((32'(w) < 32'(lim)) && (w != {CNT_W{1'b1}})) begin
            return w + CNT_W'(1);
        end
        return w;
    endfunction

    function automatic result_t mk_res(input logic [CP_W-1:0] cp, input status_t stat,
                                       input dec_state_t s, input logic lst);
        result_t r;
        r.code_point  = cp;
        r.status      = stat;
        r.bytes_used  = cnt_to_fld(s.consumed);
        r.chars_out   = cnt_to_fld(s.written);
        r.last_result = lst;
        return r;
    endfunction

    // Bad sequence of d bytes: replace or halt.
    function automatic fail_t do_fail(input dec_state_t si, input logic [2:0] d,
                                      input cfg_t c);
        fail_t f;
        f.st          = si;
        f.st.partial  = '0;
        f.st.expected = '0;
        f.st.seen     = '0;
        if (!c.fix_mode) begin
            f.st.consumed = sat_add(si.consumed, d);
            f.st.written  = inc_written(si.written, c.out_limit);
            f.r = mk_res(REPL_CHAR, ST_REPL, f.st, 1'b0);
        end else begin
            f.r = mk_res('0, ST_STOP, f.st, 1'b0);
            f.st.halted = 1'b1;
        end
        return f;
    endfunction

    dec_state_t s;
    fail_t      fr;
    logic       ended;
    logic [1:0] n;

    always_comb begin
        s     = st_cur;
        fr    = '0;
        ended = 1'b0;
        n     = 2'd0;
        for (int k = 0; k < NRES; k++) begin
            res[k] = '0;
        end

        if (s.halted) begin
            if (cfg.zero_term && in_byte == 8'h00) begin
                ended = 1'b1;
            end
        end else if (s.expected != 2'd0 && in_byte[7:6] == 2'b10) begin
            // continuation byte
            s.partial = {s.partial[CP_W-7:0], in_byte[5:0]};
            s.seen    = s.seen + 2'd1;
            if (s.seen >= s.expected) begin
                s.consumed = sat_add(s.consumed, {1'b0, s.expected} + 3'd1);
                s.written  = inc_written(s.written, cfg.out_limit);
                res[n]     = mk_res(s.partial, ST_CHAR, s, 1'b0);
                n          = n + 2'd1;
                s.partial  = '0;
                s.expected = '0;
                s.seen     = '0;
            end
        end else begin
            if (s.expected != 2'd0) begin
                // sequence broken by a non-continuation byte
                fr     = do_fail(s, {1'b0, s.seen} + 3'd1, cfg);
                s      = fr.st;
                res[n] = fr.r;
                n      = n + 2'd1;
            end
            if (!s.halted) begin
                if (cfg.zero_term && in_byte == 8'h00) begin
                    ended = 1'b1;
                end else if (32'(s.written) >= 32'(cfg.out_limit)) begin
                    res[n]   = mk_res('0, ST_FULL, s, 1'b0);
                    n        = n + 2'd1;
                    s.halted = 1'b1;
                end else begin
                    case (in_byte) inside
                        8'b0???????: begin
                            s.consumed = sat_add(s.consumed, 3'd1);
                            s.written  = inc_written(s.written, cfg.out_limit);
                            res[n]     = mk_res(CP_W'(in_byte), ST_CHAR, s, 1'b0);
                            n          = n + 2'd1;
                        end
                        8'b110?????: begin
                            s.partial  = CP_W'(in_byte[4:0]);
                            s.expected = 2'd1;
                            s.seen     = 2'd0;
                        end
                        8'b1110????: begin
                            s.partial  = CP_W'(in_byte[3:0]);
                            s.expected = 2'd2;
                            s.seen     = 2'd0;
                        end
                        8'b11110???: begin
                            s.partial  = CP_W'(in_byte[2:0]);
                            s.expected = 2'd3;
                            s.seen     = 2'd0;
                        end
                        default: begin
                            // stray continuation or F8-FF
                            fr     = do_fail(s, 3'd1, cfg);
                            s      = fr.st;
                            res[n] = fr.r;
                            n      = n + 2'd1;
                        end
                    endcase
                end
            end
        end

        if (ended || last_byte) begin
            if (!s.halted && s.expected != 2'd0) begin
                // incomplete sequence at end of string
                fr     = do_fail(s, {1'b0, s.seen} + 3'd1, cfg);
                s      = fr.st;
                res[n] = fr.r;
                n      = n + 2'd1;
            end
            res[n]     = mk_res('0, ST_END, s, 1'b1);
            n          = n + 2'd1;
            s          = '0;
            s.written  = fld_to_cnt(cfg.out_start);
        end

        st_next = s;
        res_cnt = n;
    end

endmodule

`default_nettype wire

>>> rtl/core/utf8d_outq.sv
// Result bundle register: holds up to three results of one byte and hands
// them out one per transfer. Depends on utf8d_pkg.
`default_nettype none

module utf8d_outq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load,
    input  utf8d_pkg::result_t    load_res [utf8d_pkg::NRES],
    input  logic [1:0]            load_cnt,
    output logic                  can_load,
    output logic                  out_valid,
    input  logic                  out_ready,
    output utf8d_pkg::result_t    out_res
);
    import utf8d_pkg::*;

    result_t    res_reg [NRES];
    logic [1:0] cnt_reg, cnt_next;
    logic [1:0] rd_reg, rd_next;
    logic       take, final_take;

    assign out_valid  = (cnt_reg != 2'd0);
    assign out_res    = res_reg[rd_reg];
    assign take       = out_valid && out_ready;
    assign final_take = take && (rd_reg + 2'd1 == cnt_reg);
    assign can_load   = !out_valid || final_take;

    always_comb begin
        cnt_next = cnt_reg;
        rd_next  = rd_reg;
        if (load) begin
            cnt_next = load_cnt;
            rd_next  = 2'd0;
        end else if (final_take) begin
            cnt_next = 2'd0;
            rd_next  = 2'd0;
        end else if (take) begin
            rd_next = rd_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            rd_reg  <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int k = 0; k < NRES; k++) begin
                res_reg[k] <= load_res[k];
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/utf8_to_codepoint_decoder_core.sv
// Top level of the UTF-8 to code point decoder: config registers, decoder
// state, per-byte step logic and the result bundle. Depends on utf8d_pkg,
// utf8d_step and utf8d_outq.
`default_nettype none

// The core takes one UTF-8 byte per transfer on the s_ side and returns
// decoded code points on the m_ side, each with a status kind in m_tuser.
// A byte is decoded in the cycle it is accepted; its results (none, one,
// two or three) land together in a result bundle register and leave one
// per m_ transfer. A byte can therefore be accepted every cycle as long as
// each byte yields at most one result and the sink keeps m_tready high; a
// byte that yields several results holds the input until all of them have
// left the bundle register. The next byte is taken in the same cycle the
// last result of the bundle is transferred.
// Every string closes with a summary result (status end, m_tlast high).
// s_tlast ends a string; with zero_term set a zero byte does too.
// Errors give U+FFFD (fix_mode 0) or a stop result and halt (fix_mode 1);
// the output index stops at out_limit with an output-full result. Counters
// saturate. Configuration is written through the cfg_ channel, which is
// always ready, and must only be written while the core is idle. There is
// no clearing pass: the core is ready right after reset.

module utf8_to_codepoint_decoder_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    // config write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [utf8d_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [utf8d_pkg::CFG_DATA_W-1:0]  cfg_data,
    // byte input
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,  // [7:0] in_byte
    input  logic                              s_tlast,  // last_byte
    // result output
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [20:0] code_point, [36:21] bytes_used, [52:37] chars_out, [55:53] zero
    output logic [55:0]                       m_tdata,
    output logic [2:0]                        m_tuser,  // [2:0] status
    output logic                              m_tlast   // last_result
);
    import utf8d_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    dec_state_t st_reg, st_next, st_step;
    result_t    step_res [NRES];
    logic [1:0] step_cnt;
    result_t    out_res;
    logic       can_load;
    logic       in_xfer, cfg_xfer;

    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid && cfg_ready;
    assign s_tready  = can_load;
    assign in_xfer   = s_tvalid && s_tready;

    // Config register write.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_xfer) begin
            case (cfg_index)
                REG_FIX_MODE:  cfg_next.fix_mode  = cfg_data[0];
                REG_ZERO_TERM: cfg_next.zero_term = cfg_data[0];
                REG_OUT_LIMIT: cfg_next.out_limit = cfg_data[FLD_W-1:0];
                REG_OUT_START: cfg_next.out_start = cfg_data[FLD_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    // Decoder state: a byte transfer steps it; an out_start write reloads
    // the output index only while the string has not begun.
    always_comb begin
        st_next = st_reg;
        if (in_xfer) begin
            st_next = st_step;
        end else if (cfg_xfer && cfg_index == REG_OUT_START &&
                     st_reg.consumed == '0 && st_reg.expected == 2'd0 &&
                     !st_reg.halted) begin
            st_next.written = fld_to_cnt(cfg_data[FLD_W-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fix_mode  <= 1'b0;
            cfg_reg.zero_term <= 1'b0;
            cfg_reg.out_limit <= {FLD_W{1'b1}};
            cfg_reg.out_start <= '0;
            st_reg            <= '0;
        end else begin
            cfg_reg <= cfg_next;
            st_reg  <= st_next;
        end
    end

    utf8d_step u_step (
        .cfg       (cfg_reg),
        .st_cur    (st_reg),
        .in_byte   (s_tdata),
        .last_byte (s_tlast),
        .st_next   (st_step),
        .res       (step_res),
        .res_cnt   (step_cnt)
    );

    utf8d_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (in_xfer),
        .load_res  (step_res),
        .load_cnt  (step_cnt),
        .can_load  (can_load),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {3'b000, out_res.chars_out, out_res.bytes_used, out_res.code_point};
    assign m_tuser = out_res.status;
    assign m_tlast = out_res.last_result;

    // A byte is taken only once the pending bundle is drained or draining.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (!m_tvalid || m_tready))
        else $error("input accepted while results pending");

    // Summary results carry the end status.
    a_last_is_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tuser == ST_END))
        else $error("tlast on a non-summary result");

    // Continuation progress stays below the expected length.
    a_seq_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg.expected == 2'd0) ? (st_reg.seen == 2'd0)
                                  : (st_reg.seen < st_reg.expected))
        else $error("sequence counters inconsistent");

    // A halted decoder holds no open sequence.
    a_halt_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.halted |-> (st_reg.expected == 2'd0))
        else $error("open sequence while halted");

    // Nothing is presented right after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

`default_nettype wire
